@@ rtl/json_string_unescaper_defines.svh @@
// Assertion helpers included by the top module, which carries the concurrent checks.
`ifndef JSON_STRING_UNESCAPER_DEFINES_SVH
`define JSON_STRING_UNESCAPER_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define JSU_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition that holds at every clock edge outside reset.
`define JSU_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

@@ rtl/jsu_pkg.sv @@
`timescale 1ns / 1ps
package jsu_pkg;

  localparam int MAX_STRING_BYTES = 4096;
  localparam int LEN_W = 13;
  localparam int LEN_CAP_INT = (MAX_STRING_BYTES > (2 ** LEN_W) - 1) ?
                               (2 ** LEN_W) - 1 : MAX_STRING_BYTES;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_INT);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ST_PROGRESS = 2'd0,
    ST_DONE     = 2'd1,
    ST_ERROR    = 2'd2
  } jsu_status_t;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;

  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_HT = 8'h09;

  localparam logic [7:0] UTF8_CONT  = 8'h80;
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_MASK6 = 8'h3F;
  localparam logic [15:0] CP_ONE_BYTE_LIMIT = 16'h0080;
  localparam logic [15:0] CP_TWO_BYTE_LIMIT = 16'h0800;
  localparam logic [15:0] SURR_LO = 16'hD800;
  localparam logic [15:0] SURR_HI = 16'hDFFF;

  // One decoded item waiting for the output side.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      ndata;
    logic [1:0]      nres;
    logic            err;
    logic            last;
  } jsu_entry_t;

  // Returns {valid, digit value}.
  function automatic logic [4:0] hex_value(input logic [7:0] h);
    logic [4:0] r;
    r = 5'd0;
    if (h >= 8'h30 && h <= 8'h39) r = {1'b1, h[3:0]};
    else if ((h >= 8'h61 && h <= 8'h66) || (h >= 8'h41 && h <= 8'h46))
      r = {1'b1, h[3:0] + 4'd9};
    return r;
  endfunction

endpackage

@@ rtl/jsu_if.sv @@
`timescale 1ns / 1ps
interface jsu_raw_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       byte_present;
  logic       end_of_string;

  modport source (output valid, in_byte, byte_present, end_of_string, input ready);
  modport sink (input valid, in_byte, byte_present, end_of_string, output ready);
endinterface

interface jsu_text_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic [1:0]  status;
  logic [12:0] out_length;
  logic        run_last;

  modport source (output valid, out_byte, byte_valid, status, out_length, run_last,
                  input ready);
  modport sink (input valid, out_byte, byte_valid, status, out_length, run_last,
                output ready);
endinterface

@@ rtl/json_string_unescaper.sv @@
`timescale 1ns / 1ps
// Unescapes JSON string bodies one raw byte per item and sends one result per
// output cycle while the receiver is ready. An item is accepted every cycle while
// the two-entry queue between the decoder and the output stage has room; an item
// that yields two or three UTF-8 bytes holds the output register for one result
// per byte and the queue absorbs that burst. A result passes through a queue slot
// and then the output register. Only the output port limits the rate.
module json_string_unescaper (
  input  logic        clk,
  input  logic        rst,
  jsu_raw_if.sink     raw,
  jsu_text_if.source  unescaped
);
  import jsu_pkg::*;
  `include "json_string_unescaper_defines.svh"

  jsu_entry_t push_entry, head;
  logic       push, pop, not_empty, q_full;

  jsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .raw        (raw),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  jsu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .not_empty  (not_empty),
    .full       (q_full)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop),
    .text      (unescaped)
  );

  `JSU_ASSERT_IMPLY(a_err_alone, unescaped.valid && unescaped.status == ST_ERROR, !unescaped.byte_valid && unescaped.run_last, "error result must be the only result of its item")
  `JSU_ASSERT_IMPLY(a_done_last, unescaped.valid && unescaped.status == ST_DONE, unescaped.run_last, "done status only on the last result of an item")
  `JSU_ASSERT_IMPLY(a_len_cap, unescaped.valid, unescaped.out_length <= LEN_CAP, "output length above its saturation limit")
  `JSU_ASSERT_IMPLY(a_push_room, push, !q_full, "decoder pushed into a full queue")
endmodule

@@ rtl/jsu_front.sv @@
`timescale 1ns / 1ps
module jsu_front (
  input  logic               clk,
  input  logic               rst,
  jsu_raw_if.sink            raw,
  input  logic               q_full,
  output logic               push,
  output jsu_pkg::jsu_entry_t push_entry
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    M_NORMAL  = 3'd0,
    M_BSLASH  = 3'd1,
    M_HEX1    = 3'd2,
    M_HEX2    = 3'd3,
    M_HEX3    = 3'd4,
    M_HEX4    = 3'd5,
    M_DISCARD = 3'd6
  } mode_t;

  mode_t       mode, mode_next;
  logic [15:0] code_point, code_point_next;
  logic        accept;
  logic        err;
  logic [1:0]  ndata;
  logic [2:0][7:0] bytes;
  logic [4:0]  hv;
  logic [15:0] cp_full;
  logic [7:0]  b;

  assign raw.ready = !q_full;
  assign accept    = raw.valid && !q_full;
  assign b         = raw.in_byte;
  assign hv        = hex_value(b);
  assign cp_full   = {code_point[11:0], hv[3:0]};

  always_comb begin
    mode_next       = mode;
    code_point_next = code_point;
    err             = 1'b0;
    ndata           = 2'd0;
    bytes           = '0;
    if (raw.byte_present && mode != M_DISCARD) begin
      case (mode)
        M_BSLASH: begin
          mode_next = M_NORMAL;
          ndata     = 2'd1;
          case (b)
            CH_QUOTE, CH_BACKSLASH, CH_SLASH: bytes[0] = b;
            CH_B: bytes[0] = CTL_BS;
            CH_F: bytes[0] = CTL_FF;
            CH_N: bytes[0] = CTL_LF;
            CH_R: bytes[0] = CTL_CR;
            CH_T: bytes[0] = CTL_HT;
            CH_U: begin
              ndata           = 2'd0;
              mode_next       = M_HEX1;
              code_point_next = '0;
            end
            default: begin
              ndata = 2'd0;
              err   = 1'b1;
            end
          endcase
        end
        M_HEX1, M_HEX2, M_HEX3, M_HEX4: begin
          if (!hv[4]) begin
            err = 1'b1;
          end else begin
            code_point_next = cp_full;
            case (mode)
              M_HEX1:  mode_next = M_HEX2;
              M_HEX2:  mode_next = M_HEX3;
              M_HEX3:  mode_next = M_HEX4;
              default: mode_next = M_NORMAL;
            endcase
            if (mode == M_HEX4) begin
              if (cp_full >= SURR_LO && cp_full <= SURR_HI) begin
                err = 1'b1;
              end else if (cp_full < CP_ONE_BYTE_LIMIT) begin
                ndata    = 2'd1;
                bytes[0] = cp_full[7:0];
              end else if (cp_full < CP_TWO_BYTE_LIMIT) begin
                ndata    = 2'd2;
                bytes[0] = UTF8_LEAD2 | {3'b000, cp_full[10:6]};
                bytes[1] = UTF8_CONT | (cp_full[7:0] & UTF8_MASK6);
              end else begin
                ndata    = 2'd3;
                bytes[0] = UTF8_LEAD3 | {4'b0000, cp_full[15:12]};
                bytes[1] = UTF8_CONT | (cp_full[13:6] & UTF8_MASK6);
                bytes[2] = UTF8_CONT | (cp_full[7:0] & UTF8_MASK6);
              end
            end
          end
        end
        default: begin
          if (b == CH_BACKSLASH) begin
            mode_next = M_BSLASH;
          end else begin
            ndata    = 2'd1;
            bytes[0] = b;
          end
        end
      endcase
    end
    // A string that closes with an escape still open is malformed.
    if (!err && raw.end_of_string && mode_next != M_NORMAL && mode_next != M_DISCARD)
      err = 1'b1;
    if (err) mode_next = M_DISCARD;
  end

  always_comb begin
    push_entry.bytes = bytes;
    push_entry.ndata = ndata;
    push_entry.err   = err;
    push_entry.last  = raw.end_of_string;
    if (err) push_entry.nres = 2'd1;
    else if (ndata != 2'd0) push_entry.nres = ndata;
    else if (raw.end_of_string && mode_next != M_DISCARD) push_entry.nres = 2'd1;
    else push_entry.nres = 2'd0;
    // The closing item always goes to the back end so that it restarts the count.
    push = accept && (push_entry.nres != 2'd0 || raw.end_of_string);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_NORMAL;
      code_point <= '0;
    end else if (accept) begin
      if (raw.end_of_string) begin
        mode       <= M_NORMAL;
        code_point <= '0;
      end else begin
        mode       <= mode_next;
        code_point <= code_point_next;
      end
    end
  end
endmodule

@@ rtl/jsu_queue.sv @@
`timescale 1ns / 1ps
module jsu_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  jsu_pkg::jsu_entry_t push_entry,
  input  logic                pop,
  output jsu_pkg::jsu_entry_t head,
  output logic                not_empty,
  output logic                full
);
  import jsu_pkg::*;

  jsu_entry_t          slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push, do_pop;

  assign full      = count == QCNT_W'(QDEPTH);
  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push)
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end
endmodule

@@ rtl/jsu_back.sv @@
`timescale 1ns / 1ps
module jsu_back (
  input  logic                clk,
  input  logic                rst,
  input  jsu_pkg::jsu_entry_t head,
  input  logic                not_empty,
  output logic                pop,
  jsu_text_if.source          text
);
  import jsu_pkg::*;

  logic [1:0]       idx;
  logic [LEN_W-1:0] length_count, len_inc;
  logic             out_valid;
  logic [7:0]       out_byte;
  logic             byte_valid;
  jsu_status_t      status;
  logic [LEN_W-1:0] out_length;
  logic             run_last;
  logic             can_load, load, final_res;

  assign len_inc   = (length_count < LEN_CAP) ? length_count + 1'b1 : length_count;
  assign can_load  = !out_valid || text.ready;
  assign load      = not_empty && head.nres != 2'd0 && can_load;
  assign final_res = idx == head.nres - 2'd1;
  // Entries without results (close of a discarded string) leave at once.
  assign pop       = not_empty && (head.nres == 2'd0 || (load && final_res));

  assign text.valid      = out_valid;
  assign text.out_byte   = out_byte;
  assign text.byte_valid = byte_valid;
  assign text.status     = status;
  assign text.out_length = out_length;
  assign text.run_last   = run_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      idx          <= '0;
      length_count <= '0;
    end else begin
      if (can_load) out_valid <= load;
      if (load) begin
        idx <= final_res ? 2'd0 : idx + 2'd1;
        if (!head.err && head.ndata != 2'd0) length_count <= len_inc;
      end
      if (pop && head.last) length_count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run_last <= final_res;
      if (head.err) begin
        out_byte   <= '0;
        byte_valid <= 1'b0;
        status     <= ST_ERROR;
        out_length <= length_count;
      end else if (head.ndata == 2'd0) begin
        out_byte   <= '0;
        byte_valid <= 1'b0;
        status     <= ST_DONE;
        out_length <= length_count;
      end else begin
        out_byte   <= head.bytes[idx];
        byte_valid <= 1'b1;
        status     <= (head.last && final_res) ? ST_DONE : ST_PROGRESS;
        out_length <= len_inc;
      end
    end
  end
endmodule
